/* hw/rtl/assert_macros.svh */
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define ASSERT_CHK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
// boolean condition must never be seen outside reset
`define ASSERT_NOT(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CHK(lbl, clk, rstn, prop)
`define ASSERT_NOT(lbl, clk, rstn, cond)
`endif
`endif

/* hw/rtl/tft_pkg.sv */
// types, constants and helpers of the tilt and face-down tracker
`timescale 1ns / 1ps
package tft_pkg;

  localparam int ACCEL_W    = 12;
  localparam int MG_W       = 11;
  localparam int PCT_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int PCT_MAX    = 100;

  typedef logic signed [ACCEL_W-1:0] accel_t;

  localparam accel_t ACCEL_MIN = 12'sh800;
  localparam accel_t ACCEL_MAX = 12'sh7ff;

  localparam logic [MG_W-1:0] FACE_ENTER_RST = 11'd800;
  localparam logic [MG_W-1:0] FACE_EXIT_RST  = 11'd600;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLIP_EN    = 3'd0,
    CFG_SMOOTH_PCT = 3'd1,
    CFG_FACE_ENTER = 3'd2,
    CFG_FACE_EXIT  = 3'd3,
    CFG_FACE_ZNEG  = 3'd4,
    CFG_NEG_X      = 3'd5,
    CFG_NEG_Y      = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic   int_pending;
    logic   src_active;
    logic   src_x_high;
    logic   src_x_low;
    logic   sample_valid;
    accel_t accel_x;
    accel_t accel_y;
    accel_t accel_z;
    logic   consume_motion;
  } in_t;

  typedef struct packed {
    accel_t tilt_x;
    accel_t tilt_y;
    accel_t last_z;
    logic   face_down;
    logic   orientation;
    logic   orientation_changed;
    logic   motion_event;
    logic   have_tilt;
  } out_t;

  typedef struct packed {
    logic            flip_en;
    logic [MG_W-1:0] face_enter;
    logic [MG_W-1:0] face_exit;
    logic            face_zneg;
    logic            neg_x;
    logic            neg_y;
  } cfg_t;

  // negate with the most negative code clipped to full scale
  function automatic accel_t neg_sat(accel_t v);
    accel_t r;
    if (v == ACCEL_MIN) begin
      r = ACCEL_MAX;
    end else begin
      r = -v;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/tft_cfg.sv */
// configuration registers and smoothing coefficient lookup
`timescale 1ns / 1ps
module tft_cfg #(
  parameter int FRAC_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tft_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tft_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output tft_pkg::cfg_t                     cfg_o,
  output logic [tft_pkg::ACCEL_W+FRAC_BITS+7:0] coef_o,
  output logic                              flip_off_o
);
  import tft_pkg::*;

  localparam int ACC_W      = ACCEL_W + FRAC_BITS;
  localparam int COEF_SHIFT = ACC_W + 7;
  localparam int COEF_W     = COEF_SHIFT + 1;
  localparam int TBL_N      = 1 << PCT_W;
  localparam int TBL_BITS   = TBL_N * COEF_W;

  // ceil(min(p,100) * 2^shift / 100) for every 7-bit percent code
  function automatic logic [TBL_BITS-1:0] coef_table();
    logic [TBL_BITS-1:0] tbl;
    logic [63:0]         num;
    int                  p;
    tbl = '0;
    for (p = 0; p < TBL_N; p++) begin
      num = 64'((p > PCT_MAX) ? PCT_MAX : p) << COEF_SHIFT;
      num = (num + 64'(PCT_MAX - 1)) / 64'(PCT_MAX);
      tbl[p*COEF_W +: COEF_W] = num[COEF_W-1:0];
    end
    return tbl;
  endfunction

  localparam logic [TBL_BITS-1:0] COEF_TBL = coef_table();
  localparam logic [COEF_W-1:0]   COEF_RST = COEF_W'(1) << COEF_SHIFT;

  cfg_t              cfg_q;
  logic [COEF_W-1:0] coef_q;
  logic [PCT_W-1:0]  pct;

  assign pct = cfg_wdata_i[PCT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flip_en    <= 1'b0;
      cfg_q.face_enter <= FACE_ENTER_RST;
      cfg_q.face_exit  <= FACE_EXIT_RST;
      cfg_q.face_zneg  <= 1'b0;
      cfg_q.neg_x      <= 1'b0;
      cfg_q.neg_y      <= 1'b0;
      coef_q           <= COEF_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FLIP_EN:    cfg_q.flip_en    <= cfg_wdata_i[0];
        CFG_SMOOTH_PCT: coef_q           <= COEF_TBL[pct*COEF_W +: COEF_W];
        CFG_FACE_ENTER: cfg_q.face_enter <= cfg_wdata_i[MG_W-1:0];
        CFG_FACE_EXIT:  cfg_q.face_exit  <= cfg_wdata_i[MG_W-1:0];
        CFG_FACE_ZNEG:  cfg_q.face_zneg  <= cfg_wdata_i[0];
        CFG_NEG_X:      cfg_q.neg_x      <= cfg_wdata_i[0];
        CFG_NEG_Y:      cfg_q.neg_y      <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o      = cfg_q;
  assign coef_o     = coef_q;
  // clearing flip enable forces the orientation back to upright
  assign flip_off_o = cfg_we_i && (cfg_idx_e'(cfg_idx_i) == CFG_FLIP_EN) && !cfg_wdata_i[0];

endmodule

/* hw/rtl/tft_axis.sv */
// one tilt axis: exponential smoothing step and milli-g conversion
`timescale 1ns / 1ps
module tft_axis #(
  parameter int FRAC_BITS = 8
) (
  input  logic signed [tft_pkg::ACCEL_W+FRAC_BITS-1:0] acc_i,
  input  tft_pkg::accel_t                              sample_i,
  input  logic                                         upd_i,
  input  logic                                         seeded_i,
  input  logic [tft_pkg::ACCEL_W+FRAC_BITS+7:0]        coef_i,
  output logic signed [tft_pkg::ACCEL_W+FRAC_BITS-1:0] acc_o,
  output tft_pkg::accel_t                              tilt_o
);
  import tft_pkg::*;

  localparam int ACC_W      = ACCEL_W + FRAC_BITS;
  localparam int MAG_W      = ACC_W + 1;
  localparam int COEF_SHIFT = ACC_W + 7;
  localparam int COEF_W     = COEF_SHIFT + 1;
  localparam int PROD_W     = MAG_W + COEF_W;

  logic signed [ACC_W-1:0] target;
  logic signed [MAG_W-1:0] diff;
  logic        [MAG_W-1:0] mag;
  logic        [PROD_W-1:0] prod;
  logic        [MAG_W-1:0] quot;
  logic signed [MAG_W-1:0] step;
  logic signed [MAG_W-1:0] sum;
  logic signed [ACC_W-1:0] acc_new;
  logic                    rnd;

  assign target = $signed({sample_i, {FRAC_BITS{1'b0}}});
  assign diff   = $signed({target[ACC_W-1], target}) - $signed({acc_i[ACC_W-1], acc_i});
  assign mag    = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);

  // pct*|d|/100 as |d| times a scaled reciprocal, exact for all |d| in range
  assign prod = PROD_W'(mag) * PROD_W'(coef_i);
  assign quot = prod[COEF_SHIFT +: MAG_W];
  assign step = diff[MAG_W-1] ? -$signed(quot) : $signed(quot);
  assign sum  = $signed({acc_i[ACC_W-1], acc_i}) + step;

  assign acc_new = seeded_i ? sum[ACC_W-1:0] : target;
  assign acc_o   = upd_i ? acc_new : acc_i;

  // shift toward zero: bump negative values that drop fraction bits
  assign rnd    = acc_o[ACC_W-1] && (|acc_o[FRAC_BITS-1:0]);
  assign tilt_o = $signed(acc_o[ACC_W-1:FRAC_BITS]) + $signed({{(ACCEL_W-1){1'b0}}, rnd});

endmodule

/* hw/rtl/tilt_facedown_orientation_tracker.sv */
// Tilt, face-down and orientation tracker. Every item on the input channel
// yields exactly one result beat. An item enters an input register, its
// whole update (event handling, face-down hysteresis, one multiply per tilt
// axis for the smoothing step) is computed from that register, and the
// result lands in an output register when the output side can take it, so
// one item is taken every cycle when the output side does not stall. The
// tracker state is written in the same cycle as the result register, which
// is what lets back-to-back items see each other's updates. Configuration
// writes take effect on the next cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tilt_facedown_orientation_tracker #(
  parameter int FRAC_BITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  tft_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output tft_pkg::out_t                  out_data_o,
  input  logic                           cfg_we_i,
  input  logic [tft_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tft_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import tft_pkg::*;

  localparam int ACC_W  = ACCEL_W + FRAC_BITS;
  localparam int COEF_W = ACC_W + 8;

  cfg_t              cfg;
  logic [COEF_W-1:0] coef;
  logic              flip_off;

  tft_cfg #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .coef_o      (coef),
    .flip_off_o  (flip_off)
  );

  // input register
  in_t  in_q;
  logic in_vld_q, in_vld_d;
  logic in_acc;
  logic adv;

  // result register
  out_t out_q, out_d;
  logic out_vld_q, out_vld_d;

  // tracker state
  logic signed [ACC_W-1:0] tx_acc_q, tx_acc_d;
  logic signed [ACC_W-1:0] ty_acc_q, ty_acc_d;
  accel_t                  z_q, z_d;
  logic                    seeded_q, seeded_d;
  logic                    face_q, face_d;
  logic                    orient_q, orient_d;
  logic                    motion_q, motion_d;

  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_vld_d   = in_acc || (in_vld_q && !adv);
  assign out_vld_d  = adv || (out_vld_q && out_stall_i);

  // interrupt event
  logic ev, flip_hit, orient_tgt, chg, motion_rep;

  assign ev         = in_q.int_pending && in_q.src_active;
  assign flip_hit   = ev && cfg.flip_en && (in_q.src_x_high || in_q.src_x_low);
  assign orient_tgt = !in_q.src_x_high;
  assign chg        = flip_hit && (orient_tgt != orient_q);
  assign orient_d   = flip_hit ? orient_tgt : orient_q;
  assign motion_rep = motion_q || ev;
  assign motion_d   = in_q.consume_motion ? 1'b0 : motion_rep;

  // face-down hysteresis on z
  logic signed [ACCEL_W:0] rz, enter_th, exit_th;
  logic                    enter_hit, exit_hit;

  assign rz       = {in_q.accel_z[ACCEL_W-1], in_q.accel_z};
  assign enter_th = $signed({2'b00, cfg.face_enter});
  assign exit_th  = $signed({2'b00, cfg.face_exit});
  assign enter_hit = cfg.face_zneg ? (rz < -enter_th) : (rz > enter_th);
  assign exit_hit  = cfg.face_zneg ? (rz > -exit_th) : (rz < exit_th);

  assign face_d   = in_q.sample_valid ? (face_q ? !exit_hit : enter_hit) : face_q;
  assign z_d      = in_q.sample_valid ? in_q.accel_z : z_q;
  assign seeded_d = seeded_q || in_q.sample_valid;

  // x and y swap on the way into tilt
  accel_t sx, sy, tilt_x, tilt_y;

  assign sx = cfg.neg_x ? neg_sat(in_q.accel_x) : in_q.accel_x;
  assign sy = cfg.neg_y ? neg_sat(in_q.accel_y) : in_q.accel_y;

  tft_axis #(
    .FRAC_BITS (FRAC_BITS)
  ) u_axis_x (
    .acc_i    (tx_acc_q),
    .sample_i (sy),
    .upd_i    (in_q.sample_valid),
    .seeded_i (seeded_q),
    .coef_i   (coef),
    .acc_o    (tx_acc_d),
    .tilt_o   (tilt_x)
  );

  tft_axis #(
    .FRAC_BITS (FRAC_BITS)
  ) u_axis_y (
    .acc_i    (ty_acc_q),
    .sample_i (sx),
    .upd_i    (in_q.sample_valid),
    .seeded_i (seeded_q),
    .coef_i   (coef),
    .acc_o    (ty_acc_d),
    .tilt_o   (tilt_y)
  );

  always_comb begin
    out_d.tilt_x              = tilt_x;
    out_d.tilt_y              = tilt_y;
    out_d.last_z              = z_d;
    out_d.face_down           = face_d;
    out_d.orientation         = orient_d;
    out_d.orientation_changed = chg;
    out_d.motion_event        = motion_rep;
    out_d.have_tilt           = seeded_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      tx_acc_q  <= '0;
      ty_acc_q  <= '0;
      z_q       <= '0;
      seeded_q  <= 1'b0;
      face_q    <= 1'b0;
      orient_q  <= 1'b0;
      motion_q  <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (adv) begin
        tx_acc_q <= tx_acc_d;
        ty_acc_q <= ty_acc_d;
        z_q      <= z_d;
        seeded_q <= seeded_d;
        face_q   <= face_d;
        motion_q <= motion_d;
      end
      if (flip_off) begin
        orient_q <= 1'b0;
      end else if (adv) begin
        orient_q <= orient_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_data_i;
    end
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  logic out_tilt_nz;

  assign out_tilt_nz = |{out_q.tilt_x, out_q.tilt_y};

  `ASSERT_CHK(a_seed_sticky, clk_i, rst_ni, seeded_q |=> seeded_q)
  `ASSERT_CHK(a_in_hold, clk_i, rst_ni, in_stall_o |=> in_vld_q && $stable(in_q))
  `ASSERT_CHK(a_adv_result, clk_i, rst_ni, adv |=> out_vld_q)
  `ASSERT_NOT(a_unseeded_tilt, clk_i, rst_ni, out_vld_q && !out_q.have_tilt && out_tilt_nz)

endmodule

/* bench/tilt_facedown_orientation_tracker_tb.sv */
// testbench for the tilt, face-down and orientation tracker
`timescale 1ns / 1ps
module tilt_facedown_orientation_tracker_tb;
  import tft_pkg::*;

  localparam int TILT_FRAC  = 8;
  localparam int IDLE_LIMIT = 4000;
  localparam int FREEZE_LEN = 300;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_t                   in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_t                  out_data_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  tilt_facedown_orientation_tracker #(.FRAC_BITS(TILT_FRAC)) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow registers and tracker state
  logic            flip_en_m = 1'b0;
  logic [PCT_W-1:0] pct_m    = 7'd100;
  logic [MG_W-1:0] enter_m   = FACE_ENTER_RST;
  logic [MG_W-1:0] exit_m    = FACE_EXIT_RST;
  logic            zneg_m    = 1'b0;
  logic            inv_x_m   = 1'b0;
  logic            inv_y_m   = 1'b0;

  longint tilt_x_fx = 0;
  longint tilt_y_fx = 0;
  accel_t z_seen    = '0;
  logic   primed    = 1'b0;
  logic   face_dn   = 1'b0;
  logic   inverted  = 1'b0;
  logic   motion_hold = 1'b0;

  in_t  item_q[$];
  out_t report_q[$];
  int   errors = 0;

  int   tx_gap_max = 0;
  int   rx_stall_max = 0;
  int   gap_left = 0;
  int   stall_left = 0;
  int   freeze_req = 0;
  int   freeze_ack = 0;
  int   freeze_left = 0;
  int   idle_cycles = 0;
  logic in_took = 1'b0;
  logic out_took = 1'b0;

  function automatic int neg_clip(accel_t v);
    return (v == ACCEL_MIN) ? 2047 : -int'(v);
  endfunction

  function automatic longint ease(longint prev, int s, longint pct);
    longint aim;
    aim = longint'(s) * (longint'(1) << TILT_FRAC);
    return prev + (pct * (aim - prev)) / 100;
  endfunction

  // accumulator to milli-g, truncated toward zero
  function automatic accel_t to_mg(longint acc);
    longint w;
    w = (acc < 0) ? -((-acc) >>> TILT_FRAC) : (acc >>> TILT_FRAC);
    return accel_t'(w[ACCEL_W-1:0]);
  endfunction

  function automatic out_t track_item(in_t it);
    out_t   r;
    int     sx;
    int     sy;
    int     rz;
    longint pct;
    logic   moved;
    moved = 1'b0;
    if (it.int_pending && it.src_active) begin
      motion_hold = 1'b1;
      if (flip_en_m && (it.src_x_high || it.src_x_low)) begin
        if (inverted != !it.src_x_high) begin
          inverted = !it.src_x_high;
          moved = 1'b1;
        end
      end
    end
    if (it.sample_valid) begin
      sx = inv_x_m ? neg_clip(it.accel_x) : int'(it.accel_x);
      sy = inv_y_m ? neg_clip(it.accel_y) : int'(it.accel_y);
      rz = int'(it.accel_z);
      pct = (pct_m > PCT_MAX) ? 100 : longint'(pct_m);
      z_seen = it.accel_z;
      if (!face_dn) begin
        if (zneg_m ? (rz < -int'(enter_m)) : (rz > int'(enter_m))) face_dn = 1'b1;
      end else begin
        if (zneg_m ? (rz > -int'(exit_m)) : (rz < int'(exit_m))) face_dn = 1'b0;
      end
      if (!primed) begin
        tilt_x_fx = longint'(sy) * (longint'(1) << TILT_FRAC);
        tilt_y_fx = longint'(sx) * (longint'(1) << TILT_FRAC);
        primed = 1'b1;
      end else begin
        tilt_x_fx = ease(tilt_x_fx, sy, pct);
        tilt_y_fx = ease(tilt_y_fx, sx, pct);
      end
    end
    r.tilt_x              = to_mg(tilt_x_fx);
    r.tilt_y              = to_mg(tilt_y_fx);
    r.last_z              = z_seen;
    r.face_down           = face_dn;
    r.orientation         = inverted;
    r.orientation_changed = moved;
    r.motion_event        = motion_hold;
    r.have_tilt           = primed;
    if (it.consume_motion) motion_hold = 1'b0;
    return r;
  endfunction

  function automatic void chk_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endfunction

  // sample both channels and check result beats
  always @(posedge clk_i) begin : mon_p
    out_t want;
    in_took <= in_valid_i && !in_stall_o;
    out_took <= out_valid_o && !out_stall_i;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (in_valid_i && !in_stall_o) report_q.push_back(track_item(in_data_i));
      if (out_valid_o && !out_stall_i) begin
        if (report_q.size() == 0) begin
          errors++;
          $display("%0t: result beat with none expected, got %p", $time, out_data_o);
        end else begin
          want = report_q.pop_front();
          chk_field("tilt_x", int'(want.tilt_x), int'(out_data_o.tilt_x));
          chk_field("tilt_y", int'(want.tilt_y), int'(out_data_o.tilt_y));
          chk_field("last_z", int'(want.last_z), int'(out_data_o.last_z));
          chk_field("face_down", int'(want.face_down), int'(out_data_o.face_down));
          chk_field("orientation", int'(want.orientation), int'(out_data_o.orientation));
          chk_field("orientation_changed", int'(want.orientation_changed),
                    int'(out_data_o.orientation_changed));
          chk_field("motion_event", int'(want.motion_event), int'(out_data_o.motion_event));
          chk_field("have_tilt", int'(want.have_tilt), int'(out_data_o.have_tilt));
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: timeout, no beat for %0d cycles", $time, IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // sender: one beat per queued item, random gap after each
  always @(negedge clk_i) begin : tx_p
    logic offer;
    offer = in_valid_i && !in_took;
    if (!offer && rst_ni) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (item_q.size() != 0) begin
        in_data_i <= item_q.pop_front();
        offer = 1'b1;
        gap_left = $urandom_range(0, tx_gap_max);
      end
    end
    in_valid_i <= offer;
  end

  // receiver: random stall after each result, plus an occasional long freeze
  always @(negedge clk_i) begin : rx_p
    if (freeze_req != freeze_ack) begin
      freeze_ack = freeze_req;
      freeze_left = FREEZE_LEN;
    end
    if (out_took) begin
      stall_left = $urandom_range(0, rx_stall_max);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    if (freeze_left > 0) freeze_left--;
    out_stall_i <= (stall_left > 0) || (freeze_left > 0);
  end

  task automatic set_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    case (idx)
      CFG_FLIP_EN: begin
        flip_en_m = val[0];
        if (!val[0]) inverted = 1'b0;
      end
      CFG_SMOOTH_PCT: pct_m = val[PCT_W-1:0];
      CFG_FACE_ENTER: enter_m = val[MG_W-1:0];
      CFG_FACE_EXIT:  exit_m = val[MG_W-1:0];
      CFG_FACE_ZNEG:  zneg_m = val[0];
      CFG_NEG_X:      inv_x_m = val[0];
      CFG_NEG_Y:      inv_y_m = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // hold until every queued item has come back, then let the pipe settle
  task automatic drain();
    while (item_q.size() != 0 || in_valid_i || report_q.size() != 0) @(posedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  function automatic in_t mk(int pend, int ia, int xh, int xl, int smp,
                             int x, int y, int z, int cons);
    in_t it;
    it.int_pending    = 1'(pend);
    it.src_active     = 1'(ia);
    it.src_x_high     = 1'(xh);
    it.src_x_low      = 1'(xl);
    it.sample_valid   = 1'(smp);
    it.accel_x        = accel_t'(x);
    it.accel_y        = accel_t'(y);
    it.accel_z        = accel_t'(z);
    it.consume_motion = 1'(cons);
    return it;
  endfunction

  function automatic accel_t pick_accel(int near);
    case ($urandom_range(0, 7))
      0:       return ACCEL_MIN;
      1:       return ACCEL_MAX;
      2, 3:    return accel_t'(near + $urandom_range(0, 6) - 3);
      default: return accel_t'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic in_t rand_item();
    in_t it;
    int  zc;
    case ($urandom_range(0, 3))
      0:       zc = int'(enter_m);
      1:       zc = int'(exit_m);
      2:       zc = -int'(enter_m);
      default: zc = -int'(exit_m);
    endcase
    it.int_pending    = ($urandom_range(0, 2) != 0);
    it.src_active     = ($urandom_range(0, 3) != 0);
    it.src_x_high     = 1'($urandom_range(0, 1));
    it.src_x_low      = 1'($urandom_range(0, 1));
    it.sample_valid   = ($urandom_range(0, 3) != 0);
    it.accel_x        = pick_accel(0);
    it.accel_y        = pick_accel(0);
    it.accel_z        = pick_accel(zc);
    it.consume_motion = ($urandom_range(0, 2) == 0);
    return it;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_pct();
    case ($urandom_range(0, 5))
      0:       return CFG_DATA_W'(0);
      1:       return CFG_DATA_W'(100);
      2:       return CFG_DATA_W'($urandom_range(101, 127));
      3:       return CFG_DATA_W'($urandom_range(0, 2047));
      default: return CFG_DATA_W'($urandom_range(1, 99));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_mg();
    case ($urandom_range(0, 4))
      0:       return CFG_DATA_W'(0);
      1:       return CFG_DATA_W'(2047);
      2:       return CFG_DATA_W'($urandom_range(0, 2047));
      default: return CFG_DATA_W'($urandom_range(200, 1500));
    endcase
  endfunction

  initial begin : stim_p
    int ph;
    int k;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: flipping off, default thresholds
    tx_gap_max = 4;
    rx_stall_max = 4;
    item_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
    item_q.push_back(mk(0, 1, 1, 1, 0, 0, 0, 0, 0));
    item_q.push_back(mk(1, 1, 0, 1, 0, 0, 0, 0, 1));
    item_q.push_back(mk(0, 0, 0, 0, 1, 2047, -2048, 2047, 0));
    item_q.push_back(mk(0, 0, 0, 0, 1, -2048, 2047, 599, 0));
    item_q.push_back(mk(0, 0, 0, 0, 1, 100, -100, 800, 0));
    item_q.push_back(mk(0, 0, 0, 0, 1, -333, 777, 801, 0));
    drain();

    // oversized percent is clipped, negation saturates, negative z face
    set_reg(CFG_FLIP_EN, 11'd1);
    set_reg(CFG_SMOOTH_PCT, 11'h7ff);
    set_reg(CFG_FACE_ENTER, 11'd2047);
    set_reg(CFG_FACE_EXIT, 11'd0);
    set_reg(CFG_FACE_ZNEG, 11'd1);
    set_reg(CFG_NEG_X, 11'd1);
    set_reg(CFG_NEG_Y, 11'd1);
    tx_gap_max = 0;
    rx_stall_max = 0;
    item_q.push_back(mk(1, 1, 1, 1, 0, 0, 0, 0, 0));
    item_q.push_back(mk(1, 1, 0, 1, 0, 0, 0, 0, 0));
    item_q.push_back(mk(1, 0, 1, 0, 0, 0, 0, 0, 0));
    item_q.push_back(mk(1, 1, 0, 0, 0, 0, 0, 0, 1));
    item_q.push_back(mk(1, 1, 1, 0, 0, 0, 0, 0, 0));
    item_q.push_back(mk(0, 0, 0, 0, 1, -2048, -2048, -2048, 0));
    item_q.push_back(mk(0, 0, 0, 0, 1, 5, -5, 0, 0));
    item_q.push_back(mk(0, 0, 0, 0, 1, 9, 9, 1, 0));
    item_q.push_back(mk(1, 1, 0, 1, 1, 2047, 2047, -2048, 1));
    drain();

    // clearing flip_enable while inverted forces upright; upper bits dropped
    set_reg(CFG_FLIP_EN, 11'h7fe);
    set_reg(CFG_SMOOTH_PCT, 11'd0);
    set_reg(CFG_FACE_ENTER, 11'd0);
    set_reg(CFG_FACE_EXIT, 11'd2047);
    set_reg(CFG_FACE_ZNEG, 11'd0);
    set_reg(CFG_NEG_X, 11'd0);
    set_reg(CFG_NEG_Y, 11'd0);
    tx_gap_max = 18;
    rx_stall_max = 18;
    item_q.push_back(mk(1, 1, 0, 1, 1, 1000, -1000, 1, 0));
    item_q.push_back(mk(0, 0, 0, 0, 1, -7, 7, 2046, 0));
    item_q.push_back(mk(0, 0, 0, 0, 1, 0, 0, 2047, 0));
    item_q.push_back(mk(0, 0, 0, 0, 0, 55, 55, 55, 0));
    drain();

    for (ph = 0; ph < 9; ph++) begin
      set_reg(CFG_FLIP_EN, CFG_DATA_W'($urandom_range(0, 2047)));
      set_reg(CFG_SMOOTH_PCT, pick_pct());
      set_reg(CFG_FACE_ENTER, pick_mg());
      set_reg(CFG_FACE_EXIT, pick_mg());
      set_reg(CFG_FACE_ZNEG, CFG_DATA_W'($urandom_range(0, 2047)));
      set_reg(CFG_NEG_X, CFG_DATA_W'($urandom_range(0, 2047)));
      set_reg(CFG_NEG_Y, CFG_DATA_W'($urandom_range(0, 2047)));
      tx_gap_max = ($urandom_range(0, 1) != 0) ? 18 : 0;
      rx_stall_max = ($urandom_range(0, 1) != 0) ? 18 : 0;
      if (ph == 1) begin
        // receiver freezes while the sender keeps pushing, so input stall rises
        tx_gap_max = 0;
        @(posedge clk_i);
        freeze_req++;
      end
      for (k = 0; k < 92; k++) item_q.push_back(rand_item());
      drain();
    end

    repeat (10) @(negedge clk_i);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
